// ===== rtl/htfd_pkg.sv =====
// Shared types, status codes, constants and the CRC-8 step for the
// humidity/temperature frame decoder. No dependencies.

package htfd_pkg;

    localparam int FRAME_BYTES = 7;
    localparam int POS_W       = 3;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic [9:0]  SCALE_MUL   = 10'd625;
    localparam logic [18:0] TEMP_OFFSET = 19'd50000;

    localparam int RAW_W  = 20;
    localparam int PROD_W = 30;
    localparam int TEMP_W = 19;
    localparam int HUM_W  = 17;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_BUSY = 2'd1;
    localparam logic [1:0] STAT_CRC  = 2'd2;

    localparam logic [POS_W-1:0] POS_STATUS = 3'd0;
    localparam logic [POS_W-1:0] POS_HUM_HI = 3'd1;
    localparam logic [POS_W-1:0] POS_HUM_MD = 3'd2;
    localparam logic [POS_W-1:0] POS_SPLIT  = 3'd3;
    localparam logic [POS_W-1:0] POS_TMP_MD = 3'd4;
    localparam logic [POS_W-1:0] POS_TMP_LO = 3'd5;

    typedef struct packed {
        logic accept;
        logic mul_en;
        logic load_en;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_byte;
        logic out_free;
    } dp_stat_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/htfd_ctrl.sv =====
// Controller for the frame decoder: sequences byte intake, scaling and
// result load. Depends on htfd_pkg.

module htfd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  htfd_pkg::dp_stat_t stat,
    output htfd_pkg::ctrl_cmd_t cmd
);
    import htfd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready    = (state_reg == ST_IDLE);
    assign cmd.accept  = s_tvalid && s_tready;
    assign cmd.mul_en  = (state_reg == ST_MUL);
    assign cmd.load_en = (state_reg == ST_LOAD) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept && stat.last_byte)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/htfd_datapath.sv =====
// Datapath for the frame decoder: byte position, CRC-8, raw field unpack,
// scaling, last good readings and the result register. Depends on htfd_pkg.

module htfd_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  htfd_pkg::ctrl_cmd_t cmd,
    output htfd_pkg::dp_stat_t  stat,
    input  logic [7:0]          rx_byte,
    input  logic                first_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          out_status,
    output logic signed [18:0]  out_temp,
    output logic [16:0]         out_hum
);
    import htfd_pkg::*;

    logic [POS_W-1:0]  pos_reg;
    logic [7:0]        crc_reg;
    logic              busy_reg;
    logic [RAW_W-1:0]  hum_raw_reg;
    logic [RAW_W-1:0]  tmp_raw_reg;
    logic [1:0]        frame_stat_reg;
    logic [PROD_W-1:0] tmp_prod_reg;
    logic [PROD_W-1:0] hum_prod_reg;
    logic signed [TEMP_W-1:0] stored_temp_reg;
    logic [HUM_W-1:0]  stored_hum_reg;
    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic signed [TEMP_W-1:0] out_temp_reg;
    logic [HUM_W-1:0]  out_hum_reg;

    logic [POS_W-1:0]  pos_eff;
    logic [7:0]        crc_start;
    logic [7:0]        crc_new;
    logic              last_byte;
    logic              busy_next;
    logic [RAW_W-1:0]  hum_raw_next;
    logic [RAW_W-1:0]  tmp_raw_next;
    logic [14:0]       tmp_q;
    logic [13:0]       hum_q;
    logic [17:0]       tmp_x10;
    logic [HUM_W-1:0]  hum_x10;
    logic signed [TEMP_W-1:0] tmp_milli;

    assign pos_eff   = first_byte ? POS_STATUS : pos_reg;
    assign crc_start = first_byte ? CRC_INIT : crc_reg;
    assign crc_new   = crc8_byte(crc_start, rx_byte);
    assign last_byte = (pos_eff >= LAST_POS);

    assign stat.last_byte = last_byte;
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        busy_next    = busy_reg;
        hum_raw_next = hum_raw_reg;
        tmp_raw_next = tmp_raw_reg;
        unique case (pos_eff)
            POS_STATUS: busy_next = rx_byte[7];
            POS_HUM_HI: hum_raw_next = {rx_byte, 12'd0};
            POS_HUM_MD: hum_raw_next = {hum_raw_reg[19:12], rx_byte, 4'd0};
            POS_SPLIT:
            begin
                hum_raw_next = {hum_raw_reg[19:4], rx_byte[7:4]};
                tmp_raw_next = {rx_byte[3:0], 16'd0};
            end
            POS_TMP_MD: tmp_raw_next = {tmp_raw_reg[19:16], rx_byte, 8'd0};
            POS_TMP_LO: tmp_raw_next = {tmp_raw_reg[19:8], rx_byte};
            default:    busy_next = busy_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            crc_reg        <= CRC_INIT;
            busy_reg       <= 1'b0;
            hum_raw_reg    <= '0;
            tmp_raw_reg    <= '0;
            frame_stat_reg <= STAT_OK;
        end
        else if (cmd.accept)
        begin
            busy_reg    <= busy_next;
            hum_raw_reg <= hum_raw_next;
            tmp_raw_reg <= tmp_raw_next;
            if (last_byte)
            begin
                pos_reg <= '0;
                crc_reg <= CRC_INIT;
                priority if (busy_next)
                    frame_stat_reg <= STAT_BUSY;
                else if (crc_new != 8'd0)
                    frame_stat_reg <= STAT_CRC;
                else
                    frame_stat_reg <= STAT_OK;
            end
            else
            begin
                pos_reg <= pos_eff + POS_W'(1);
                crc_reg <= crc_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            tmp_prod_reg <= PROD_W'(tmp_raw_reg) * PROD_W'(SCALE_MUL);
            hum_prod_reg <= PROD_W'(hum_raw_reg) * PROD_W'(SCALE_MUL);
        end
    end

    assign tmp_q     = tmp_prod_reg[29:15];
    assign hum_q     = hum_prod_reg[29:16];
    assign tmp_x10   = {tmp_q, 3'd0} + {2'd0, tmp_q, 1'b0};
    assign hum_x10   = {hum_q, 3'd0} + {2'd0, hum_q, 1'b0};
    assign tmp_milli = $signed({1'b0, tmp_x10}) - $signed(TEMP_OFFSET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_temp_reg <= '0;
            stored_hum_reg  <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= STAT_OK;
            out_temp_reg    <= '0;
            out_hum_reg     <= '0;
        end
        else if (cmd.load_en)
        begin
            out_valid_reg  <= 1'b1;
            out_status_reg <= frame_stat_reg;
            if (frame_stat_reg == STAT_OK)
            begin
                stored_temp_reg <= tmp_milli;
                stored_hum_reg  <= hum_x10;
                out_temp_reg    <= tmp_milli;
                out_hum_reg     <= hum_x10;
            end
            else
            begin
                out_temp_reg <= stored_temp_reg;
                out_hum_reg  <= stored_hum_reg;
            end
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_temp   = out_temp_reg;
    assign out_hum    = out_hum_reg;

endmodule

// ===== rtl/humidity_temp_frame_decoder_unit.sv =====
// Top level of the humidity/temperature frame decoder.
// Depends on htfd_pkg, htfd_ctrl and htfd_datapath.
//
// Channel | Dir | Beat contents
// s_*     | in  | one frame byte; tdata = rx_byte, tuser = first_byte
// m_*     | out | one result per frame; tuser = status, tdata = temp, humidity
//
// A byte that does not end a frame is only taken in. The final byte passes
// through intake, the ST_MUL state in the 20x10 scaling multipliers and the
// ST_LOAD state that scales and loads the result register; the load waits
// while the prior result is unread. Reset is asynchronous, active low, and
// leaves the decoder at frame start. s_tready drops in the ST_MUL and ST_LOAD
// states after a frame's last byte, and stays low while the load waits.

module humidity_temp_frame_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] first_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [18:0] temperature_milli_c, [35:19] humidity_milli_pct
    output logic [1:0]  m_tuser    // [1:0] status
);
    import htfd_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    logic signed [TEMP_W-1:0] out_temp;
    logic [HUM_W-1:0]         out_hum;

    htfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    htfd_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .rx_byte    (s_tdata),
        .first_byte (s_tuser),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_temp   (out_temp),
        .out_hum    (out_hum)
    );

    assign m_tdata = {4'd0, out_hum, out_temp};

endmodule
